### rtl/tsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

   localparam int NUM_THRUSTERS   = 6;
   localparam int WIDTH_W         = 12;
   localparam int CHAN_W          = 7;
   localparam int COOLDOWN_W      = 16;
   localparam int COUNT_W         = 16;
   localparam int OP_W            = 2;
   localparam int MASK_W          = NUM_THRUSTERS;
   localparam int BYTE_W          = 8;
   localparam int CSR_INDEX_W     = 4;
   localparam int CSR_DATA_W      = 16;
   localparam int FRAME_LEN       = 4;
   localparam int BYTES_PER_RUN   = NUM_THRUSTERS * FRAME_LEN;
   localparam int BYTE_IDX_W      = $clog2(BYTES_PER_RUN);
   localparam int THR_IDX_W       = $clog2(NUM_THRUSTERS);
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [BYTE_W-1:0]     SET_TARGET_CMD = 8'h84;
   localparam logic [WIDTH_W-1:0]    MIRROR_SUM     = 12'd3000;
   localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET = 16'd1000;
   localparam logic [WIDTH_W-1:0]    NEUTRAL_RESET  = 12'd1500;
   localparam logic [NUM_THRUSTERS-1:0][CHAN_W-1:0] CHAN_RESET =
      {7'd6, 7'd8, 7'd2, 7'd4, 7'd10, 7'd0};

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_CHAN_FIRST = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CHAN_LAST  = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_COOLDOWN   = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_NEUTRAL    = 4'd7;

   // Byte positions inside one set-target frame.
   localparam logic [1:0] FRAME_POS_CMD  = 2'd0;
   localparam logic [1:0] FRAME_POS_CHAN = 2'd1;
   localparam logic [1:0] FRAME_POS_LO   = 2'd2;
   localparam logic [1:0] FRAME_POS_HI   = 2'd3;

   typedef enum logic [OP_W-1:0] {
      OP_COMMAND = 2'd0,
      OP_BREACH  = 2'd1,
      OP_TICK    = 2'd2
   } op_type;

   typedef logic [NUM_THRUSTERS-1:0][WIDTH_W-1:0] job_type;

   typedef struct packed {
      logic [NUM_THRUSTERS-1:0][CHAN_W-1:0] chan;
      logic [COOLDOWN_W-1:0]                cooldown;
      logic [WIDTH_W-1:0]                   neutral;
   } cfg_type;

   typedef struct packed {
      logic               lockout;
      logic [COUNT_W-1:0] ms_count;
   } front_stat_type;

endpackage

`default_nettype wire

### rtl/tsc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsc_req_if;
   logic                           valid;
   logic                           ready;
   logic [tsc_pkg::OP_W-1:0]       op;
   logic [tsc_pkg::WIDTH_W-1:0]    width_0;
   logic [tsc_pkg::WIDTH_W-1:0]    width_1;
   logic [tsc_pkg::WIDTH_W-1:0]    width_2;
   logic [tsc_pkg::WIDTH_W-1:0]    width_3;
   logic [tsc_pkg::WIDTH_W-1:0]    width_4;
   logic [tsc_pkg::WIDTH_W-1:0]    width_5;
   logic [tsc_pkg::MASK_W-1:0]     reverse_mask;

   modport source (output valid, op, width_0, width_1, width_2, width_3, width_4, width_5,
                   reverse_mask, input ready);
   modport sink (input valid, op, width_0, width_1, width_2, width_3, width_4, width_5,
                 reverse_mask, output ready);
endinterface

`default_nettype wire

### rtl/tsc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tsc_pkg::BYTE_W-1:0]   out_byte;
   logic                         last_byte;

   modport source (output valid, out_byte, last_byte, input ready);
   modport sink (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

### rtl/tsc_csr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tsc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tsc_pkg::CSR_INDEX_W-1:0]   index;
   logic [tsc_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/tsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tsc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   tsc_req_if.sink                        req_ch,
   input  wire tsc_pkg::cfg_type          cfg,
   input  wire logic                      queue_full,
   output logic                           push,
   output tsc_pkg::job_type               push_job,
   output tsc_pkg::front_stat_type        stat
);

   logic                             lockout_ff, lockout_in;
   logic [tsc_pkg::COUNT_W-1:0]      ms_ff, ms_in;
   logic                             accept;
   logic                             lock_now;
   tsc_pkg::job_type                 cmd_job;
   tsc_pkg::job_type                 neutral_job;
   tsc_pkg::job_type                 raw_job;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && req_ch.ready;

   assign raw_job = {req_ch.width_5, req_ch.width_4, req_ch.width_3,
                     req_ch.width_2, req_ch.width_1, req_ch.width_0};

   always_comb begin
      for (int i = 0; i < tsc_pkg::NUM_THRUSTERS; i++) begin
         neutral_job[i] = cfg.neutral;
         // Mirroring wraps in 12 bits, as the width field does.
         cmd_job[i] = req_ch.reverse_mask[i] ? (tsc_pkg::MIRROR_SUM - raw_job[i])
                                             : raw_job[i];
      end
   end

   // The lockout lifts only when a command arrives after the cooldown.
   assign lock_now = lockout_ff && !(ms_ff > cfg.cooldown);

   always_comb begin
      lockout_in = lockout_ff;
      ms_in      = ms_ff;
      push       = 1'b0;
      push_job   = neutral_job;
      if (accept) begin
         case (req_ch.op)
            tsc_pkg::OP_COMMAND: begin
               lockout_in = lock_now;
               push       = 1'b1;
               push_job   = lock_now ? neutral_job : cmd_job;
            end
            tsc_pkg::OP_BREACH: begin
               lockout_in = 1'b1;
               ms_in      = '0;
               push       = 1'b1;
            end
            tsc_pkg::OP_TICK: begin
               if (ms_ff != '1) begin
                  ms_in = ms_ff + tsc_pkg::COUNT_W'(1);
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= 1'b0;
         ms_ff      <= '0;
      end else begin
         lockout_ff <= lockout_in;
         ms_ff      <= ms_in;
      end
   end

   assign stat.lockout  = lockout_ff;
   assign stat.ms_count = ms_ff;

endmodule

`default_nettype wire

### rtl/tsc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tsc_queue #(
   parameter int DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tsc_pkg::job_type   push_job,
   input  wire logic               pop,
   output logic                    full,
   output logic                    not_empty,
   output tsc_pkg::job_type        head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tsc_pkg::job_type      entries_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head_job  = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### rtl/tsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tsc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tsc_pkg::cfg_type   cfg,
   input  wire logic               job_avail,
   input  wire tsc_pkg::job_type   head_job,
   output logic                    pop,
   tsc_rsp_if.source               rsp_ch
);

   localparam logic [tsc_pkg::BYTE_IDX_W-1:0] LAST_IDX =
      tsc_pkg::BYTE_IDX_W'(tsc_pkg::BYTES_PER_RUN - 1);

   tsc_pkg::job_type                   job_ff, job_in;
   logic                               job_valid_ff, job_valid_in;
   logic [tsc_pkg::BYTE_IDX_W-1:0]     idx_ff, idx_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [tsc_pkg::BYTE_W-1:0]         byte_ff, byte_in;
   logic                               last_ff, last_in;
   logic                               slot_free;
   logic                               advance;
   logic                               run_done;
   logic [tsc_pkg::THR_IDX_W-1:0]      thr;
   logic [1:0]                         pos;
   logic [tsc_pkg::WIDTH_W+1:0]        quarter;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign advance   = job_valid_ff && slot_free;
   assign run_done  = advance && (idx_ff == LAST_IDX);
   assign pop       = job_avail && (!job_valid_ff || run_done);

   assign thr     = idx_ff[tsc_pkg::BYTE_IDX_W-1:2];
   assign pos     = idx_ff[1:0];
   assign quarter = {job_ff[thr], 2'b00};

   always_comb begin
      case (pos)
         tsc_pkg::FRAME_POS_CMD:  byte_in = tsc_pkg::SET_TARGET_CMD;
         tsc_pkg::FRAME_POS_CHAN: byte_in = {1'b0, cfg.chan[thr]};
         tsc_pkg::FRAME_POS_LO:   byte_in = {1'b0, quarter[6:0]};
         tsc_pkg::FRAME_POS_HI:   byte_in = {1'b0, quarter[13:7]};
         default:                 byte_in = tsc_pkg::SET_TARGET_CMD;
      endcase
      last_in = (idx_ff == LAST_IDX);
   end

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         job_in       = head_job;
         job_valid_in = 1'b1;
         idx_in       = '0;
      end else if (run_done) begin
         job_valid_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + tsc_pkg::BYTE_IDX_W'(1);
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (advance) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_byte  = byte_ff;
   assign rsp_ch.last_byte = last_ff;

endmodule

`default_nettype wire

### rtl/thruster_servo_command_framer_core.sv
// A command or breach run's first byte passes the job queue, the job register and the output
// byte register. Throughput: one byte per cycle while the output is ready; a run is 24 bytes,
// set by the byte serializer, and the front keeps taking transactions while the job queue
// has room. Reset clears the lockout, the millisecond counter, the job queue and the output
// stage, and returns every configuration register to its default.
`timescale 1ns / 1ps
`default_nettype none

module thruster_servo_command_framer_core #(
   parameter int QUEUE_DEPTH = tsc_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tsc_req_if.sink     req_ch,
   tsc_rsp_if.source   rsp_ch,
   tsc_csr_if.sink     csr_ch
);

   tsc_pkg::cfg_type          cfg_ff, cfg_in;
   tsc_pkg::front_stat_type   front_stat;
   tsc_pkg::job_type          push_job;
   tsc_pkg::job_type          head_job;
   logic                      push;
   logic                      pop;
   logic                      queue_full;
   logic                      queue_not_empty;
   logic                      csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_ch.index) inside
            [tsc_pkg::REG_CHAN_FIRST:tsc_pkg::REG_CHAN_LAST]: begin
               cfg_in.chan[csr_ch.index[tsc_pkg::THR_IDX_W-1:0]] =
                  csr_ch.data[tsc_pkg::CHAN_W-1:0];
            end
            tsc_pkg::REG_COOLDOWN: begin
               cfg_in.cooldown = csr_ch.data[tsc_pkg::COOLDOWN_W-1:0];
            end
            tsc_pkg::REG_NEUTRAL: begin
               cfg_in.neutral = csr_ch.data[tsc_pkg::WIDTH_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chan     <= tsc_pkg::CHAN_RESET;
         cfg_ff.cooldown <= tsc_pkg::COOLDOWN_RESET;
         cfg_ff.neutral  <= tsc_pkg::NEUTRAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job),
      .stat       (front_stat)
   );

   tsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   tsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_avail (queue_not_empty),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

   // The front must never hand a job to a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("job pushed into a full queue");

   // A breach locks out and restarts the millisecond count.
   a_breach_locks: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && req_ch.op == tsc_pkg::OP_BREACH)
      |=> (front_stat.lockout && front_stat.ms_count == '0))
      else $error("breach did not set the lockout");

   // The millisecond count only goes down on a breach.
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.valid && req_ch.ready && req_ch.op == tsc_pkg::OP_BREACH)
      |=> front_stat.ms_count >= $past(front_stat.ms_count))
      else $error("millisecond count went down without a breach");

endmodule

`default_nettype wire
